// ----- rtl/ced_pkg.sv -----
// ----------------------------------------------------------------------------
// ced_pkg
// Shared types and codes for the command event statistics block: event
// actions, command kinds, statistic indexes and sequencer states.
// ----------------------------------------------------------------------------
package ced_pkg;

  localparam int DATA_W = 64;
  localparam int ACT_W  = 3;
  localparam int KIND_W = 8;
  localparam int IDX_W  = 4;

  typedef logic [ACT_W-1:0]  action_t;
  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [IDX_W-1:0]  stat_idx_t;

  // event actions
  localparam action_t ACT_SUBMIT  = 3'd0;
  localparam action_t ACT_COPY    = 3'd1;
  localparam action_t ACT_ALLOC   = 3'd2;
  localparam action_t ACT_WAIT    = 3'd3;
  localparam action_t ACT_ERROR   = 3'd4;
  localparam action_t ACT_TIMEOUT = 3'd5;
  localparam action_t ACT_READ    = 3'd6;
  localparam action_t ACT_CLEAR   = 3'd7;

  // submitted command kinds with a counter of their own
  localparam kind_t KIND_COPY    = 8'd1;
  localparam kind_t KIND_KERNEL  = 8'd2;
  localparam kind_t KIND_ALLOC   = 8'd3;
  localparam kind_t KIND_FREE    = 8'd4;
  localparam kind_t KIND_BARRIER = 8'd5;

  // statistic indexes, in dump order
  localparam stat_idx_t STAT_SUBMIT   = 4'd0;
  localparam stat_idx_t STAT_COPY     = 4'd1;
  localparam stat_idx_t STAT_KERNEL   = 4'd2;
  localparam stat_idx_t STAT_ALLOC    = 4'd3;
  localparam stat_idx_t STAT_FREE     = 4'd4;
  localparam stat_idx_t STAT_BARRIER  = 4'd5;
  localparam stat_idx_t STAT_COPIED   = 4'd6;
  localparam stat_idx_t STAT_ALLOCATED = 4'd7;
  localparam stat_idx_t STAT_WCOUNT   = 4'd8;
  localparam stat_idx_t STAT_WAVG     = 4'd9;
  localparam stat_idx_t STAT_WMIN     = 4'd10;
  localparam stat_idx_t STAT_WMAX     = 4'd11;
  localparam stat_idx_t STAT_ERROR    = 4'd12;
  localparam stat_idx_t STAT_TIMEOUT  = 4'd13;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUBMIT,
    ST_KIND,
    ST_ADD,
    ST_WMIN,
    ST_WMAX,
    ST_WSUM,
    ST_WCNT,
    ST_DIV,
    ST_READ
  } state_t;

endpackage

// ----- rtl/ced_div.sv -----
// ----------------------------------------------------------------------------
// ced_div
// Radix-2 restoring divider, one quotient bit per cycle. A zero divisor
// gives a zero quotient.
// ----------------------------------------------------------------------------
module ced_div #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CNT_W = $clog2(W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     quo_r;
  logic [W-1:0]     dvs_r;
  logic             zero_r;

  logic [W:0]       shifted;
  logic [W+1:0]     diff;
  logic             borrow;

  // bring down the next dividend bit, which sits at the top of quo_r
  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};
  assign borrow  = diff[W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= dividend;
      dvs_r  <= divisor;
      zero_r <= (divisor == '0);
    end else if (busy_r) begin
      rem_r <= borrow ? shifted[W-1:0] : diff[W-1:0];
      quo_r <= {quo_r[W-2:0], ~borrow};
    end
  end

  assign done     = done_r;
  assign quotient = zero_r ? '0 : quo_r;

endmodule

// ----- rtl/command_event_statistics_core.sv -----
// ----------------------------------------------------------------------------
// command_event_statistics_core
// Performance counters for a command stream: submit, per-kind, byte, wait
// time and error statistics, read back one at a time by index.
// ----------------------------------------------------------------------------
// One event word is taken at a time; in_stall stays high until the event has
// been worked through. All counter updates share one adder/comparator, one
// operation per cycle: a copy, alloc, error or timeout event takes an add
// step after acceptance, a submit a step for the total and then a step for
// the per-kind counter when its kind has one, a clear none, and a read its
// load step, held while the previous result still sits unclaimed in the
// output register. A wait sample takes ALU steps for min, max, sum and count,
// followed by the average division in a bit-serial divider. Counters are
// COUNTER_BITS wide and wrap; amounts are truncated to that width, and read
// values are zero-extended to 64 bits.
module command_event_statistics_core #(
  parameter int COUNTER_BITS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [ced_pkg::ACT_W-1:0]  in_action,
  input  logic [ced_pkg::KIND_W-1:0] in_command_type,
  input  logic [ced_pkg::DATA_W-1:0] in_amount,
  input  logic [ced_pkg::IDX_W-1:0]  in_stat_index,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ced_pkg::DATA_W-1:0] out_read_value,
  output logic [ced_pkg::IDX_W-1:0]  out_read_index
);

  localparam int CB = COUNTER_BITS;

  ced_pkg::state_t    state_r, state_nxt;

  // latched event word
  ced_pkg::action_t   act_r;
  ced_pkg::kind_t     kind_r;
  logic [CB-1:0]      amt_r;
  ced_pkg::stat_idx_t idx_r;

  logic [CB-1:0] submit_count_r;
  logic [CB-1:0] copy_count_r;
  logic [CB-1:0] kernel_count_r;
  logic [CB-1:0] alloc_count_r;
  logic [CB-1:0] free_count_r;
  logic [CB-1:0] barrier_count_r;
  logic [CB-1:0] copied_bytes_r;
  logic [CB-1:0] allocated_bytes_r;
  logic [CB-1:0] wait_count_r;
  logic [CB-1:0] wait_sum_r;
  logic [CB-1:0] wait_min_r;
  logic [CB-1:0] wait_max_r;
  logic [CB-1:0] wait_avg_r;
  logic [CB-1:0] error_count_r;
  logic [CB-1:0] timeout_count_r;

  logic                        out_valid_r;
  logic [ced_pkg::DATA_W-1:0]  out_value_r;
  ced_pkg::stat_idx_t          out_index_r;

  // shared unit
  logic [CB-1:0] alu_a, alu_b, alu_sum;
  logic [CB:0]   alu_diff;
  logic          alu_lt;

  logic          in_acc;
  logic          out_load;
  logic          div_done;
  logic [CB-1:0] div_quot;
  logic [CB-1:0] stat_sel;

  assign in_stall = (state_r != ced_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign alu_sum  = alu_a + alu_b;
  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_lt   = alu_diff[CB];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ced_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_action)
            ced_pkg::ACT_SUBMIT:  state_nxt = ced_pkg::ST_SUBMIT;
            ced_pkg::ACT_COPY,
            ced_pkg::ACT_ALLOC,
            ced_pkg::ACT_ERROR,
            ced_pkg::ACT_TIMEOUT: state_nxt = ced_pkg::ST_ADD;
            ced_pkg::ACT_WAIT:    state_nxt = ced_pkg::ST_WMIN;
            ced_pkg::ACT_READ:    state_nxt = ced_pkg::ST_READ;
            default:              state_nxt = ced_pkg::ST_IDLE;
          endcase
        end
      end
      ced_pkg::ST_SUBMIT: begin
        if (kind_r inside {[ced_pkg::KIND_COPY:ced_pkg::KIND_BARRIER]}) begin
          state_nxt = ced_pkg::ST_KIND;
        end else begin
          state_nxt = ced_pkg::ST_IDLE;
        end
      end
      ced_pkg::ST_KIND: state_nxt = ced_pkg::ST_IDLE;
      ced_pkg::ST_ADD:  state_nxt = ced_pkg::ST_IDLE;
      ced_pkg::ST_WMIN: state_nxt = ced_pkg::ST_WMAX;
      ced_pkg::ST_WMAX: state_nxt = ced_pkg::ST_WSUM;
      ced_pkg::ST_WSUM: state_nxt = ced_pkg::ST_WCNT;
      ced_pkg::ST_WCNT: state_nxt = ced_pkg::ST_DIV;
      ced_pkg::ST_DIV: begin
        if (div_done) state_nxt = ced_pkg::ST_IDLE;
      end
      ced_pkg::ST_READ: begin
        if (out_load) state_nxt = ced_pkg::ST_IDLE;
      end
      default: state_nxt = ced_pkg::ST_IDLE;
    endcase
  end

  // operand selection for the shared unit
  always_comb begin
    alu_a    = '0;
    alu_b    = CB'(1);
    out_load = 1'b0;
    case (state_r)
      ced_pkg::ST_SUBMIT: alu_a = submit_count_r;
      ced_pkg::ST_KIND: begin
        case (kind_r)
          ced_pkg::KIND_COPY:    alu_a = copy_count_r;
          ced_pkg::KIND_KERNEL:  alu_a = kernel_count_r;
          ced_pkg::KIND_ALLOC:   alu_a = alloc_count_r;
          ced_pkg::KIND_FREE:    alu_a = free_count_r;
          default:               alu_a = barrier_count_r;
        endcase
      end
      ced_pkg::ST_ADD: begin
        case (act_r)
          ced_pkg::ACT_COPY: begin
            alu_a = copied_bytes_r;
            alu_b = amt_r;
          end
          ced_pkg::ACT_ALLOC: begin
            alu_a = allocated_bytes_r;
            alu_b = amt_r;
          end
          ced_pkg::ACT_ERROR: alu_a = error_count_r;
          default:            alu_a = timeout_count_r;
        endcase
      end
      ced_pkg::ST_WMIN: begin
        alu_a = amt_r;
        alu_b = wait_min_r;
      end
      ced_pkg::ST_WMAX: begin
        alu_a = wait_max_r;
        alu_b = amt_r;
      end
      ced_pkg::ST_WSUM: begin
        alu_a = wait_sum_r;
        alu_b = amt_r;
      end
      ced_pkg::ST_WCNT: alu_a = wait_count_r;
      ced_pkg::ST_READ: out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_comb begin
    case (idx_r)
      ced_pkg::STAT_SUBMIT:    stat_sel = submit_count_r;
      ced_pkg::STAT_COPY:      stat_sel = copy_count_r;
      ced_pkg::STAT_KERNEL:    stat_sel = kernel_count_r;
      ced_pkg::STAT_ALLOC:     stat_sel = alloc_count_r;
      ced_pkg::STAT_FREE:      stat_sel = free_count_r;
      ced_pkg::STAT_BARRIER:   stat_sel = barrier_count_r;
      ced_pkg::STAT_COPIED:    stat_sel = copied_bytes_r;
      ced_pkg::STAT_ALLOCATED: stat_sel = allocated_bytes_r;
      ced_pkg::STAT_WCOUNT:    stat_sel = wait_count_r;
      ced_pkg::STAT_WAVG:      stat_sel = wait_avg_r;
      ced_pkg::STAT_WMIN:      stat_sel = wait_min_r;
      ced_pkg::STAT_WMAX:      stat_sel = wait_max_r;
      ced_pkg::STAT_ERROR:     stat_sel = error_count_r;
      ced_pkg::STAT_TIMEOUT:   stat_sel = timeout_count_r;
      default:                 stat_sel = '0;
    endcase
  end

  // average = sum / count; sum is already updated when the count step runs
  ced_div #(
    .W (CB)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ced_pkg::ST_WCNT),
    .dividend (wait_sum_r),
    .divisor  (alu_sum),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ced_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r  <= in_action;
      kind_r <= in_command_type;
      amt_r  <= in_amount[CB-1:0];
      idx_r  <= in_stat_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && in_action == ced_pkg::ACT_CLEAR)) begin
      submit_count_r    <= '0;
      copy_count_r      <= '0;
      kernel_count_r    <= '0;
      alloc_count_r     <= '0;
      free_count_r      <= '0;
      barrier_count_r   <= '0;
      copied_bytes_r    <= '0;
      allocated_bytes_r <= '0;
      wait_count_r      <= '0;
      wait_sum_r        <= '0;
      wait_min_r        <= '1;
      wait_max_r        <= '0;
      wait_avg_r        <= '0;
      error_count_r     <= '0;
      timeout_count_r   <= '0;
    end else begin
      case (state_r)
        ced_pkg::ST_SUBMIT: submit_count_r <= alu_sum;
        ced_pkg::ST_KIND: begin
          case (kind_r)
            ced_pkg::KIND_COPY:   copy_count_r    <= alu_sum;
            ced_pkg::KIND_KERNEL: kernel_count_r  <= alu_sum;
            ced_pkg::KIND_ALLOC:  alloc_count_r   <= alu_sum;
            ced_pkg::KIND_FREE:   free_count_r    <= alu_sum;
            default:              barrier_count_r <= alu_sum;
          endcase
        end
        ced_pkg::ST_ADD: begin
          case (act_r)
            ced_pkg::ACT_COPY:  copied_bytes_r    <= alu_sum;
            ced_pkg::ACT_ALLOC: allocated_bytes_r <= alu_sum;
            ced_pkg::ACT_ERROR: error_count_r     <= alu_sum;
            default:            timeout_count_r   <= alu_sum;
          endcase
        end
        ced_pkg::ST_WMIN: begin
          if (alu_lt) wait_min_r <= amt_r;
        end
        ced_pkg::ST_WMAX: begin
          if (alu_lt) wait_max_r <= amt_r;
        end
        ced_pkg::ST_WSUM: wait_sum_r   <= alu_sum;
        ced_pkg::ST_WCNT: wait_count_r <= alu_sum;
        ced_pkg::ST_DIV: begin
          if (div_done) wait_avg_r <= div_quot;
        end
        default: ;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= ced_pkg::DATA_W'(stat_sel);
      out_index_r <= idx_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_read_index = out_index_r;

endmodule

// ----- verif/tb_command_event_statistics_core.sv -----
// ----------------------------------------------------------------------------
// tb_command_event_statistics_core
// Self-checking bench for the command event statistics block. A table of
// directed events (reset values, counter wrap, wait extremes, spare indexes,
// clear) is followed by random event traffic with random gaps and output
// back-pressure. Every event is run through a shadow copy of the counters;
// each read word is checked in order against it or against a pinned value.
// ----------------------------------------------------------------------------
module tb_command_event_statistics_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_W = 64;
  localparam logic [ced_pkg::DATA_W-1:0] ALL_ONES = {ced_pkg::DATA_W{1'b1}};
  localparam logic [ced_pkg::DATA_W-1:0] CNT_MASK = ALL_ONES >> (ced_pkg::DATA_W - CNT_W);
  localparam ced_pkg::stat_idx_t STAT_SPARE_LO = 4'd14;
  localparam ced_pkg::stat_idx_t STAT_SPARE_HI = 4'd15;
  localparam int RANDOM_ITEMS = 1525;

  typedef struct packed {
    ced_pkg::action_t               action;
    ced_pkg::kind_t                 kind;
    logic [ced_pkg::DATA_W-1:0]     amount;
    ced_pkg::stat_idx_t             index;
    logic                           pinned;
    logic [ced_pkg::DATA_W-1:0]     pinned_value;
  } stim_t;

  typedef struct packed {
    logic [ced_pkg::DATA_W-1:0] value;
    ced_pkg::stat_idx_t         index;
  } read_word_t;

  typedef struct packed {
    logic [ced_pkg::DATA_W-1:0] submits, copies, kernels, allocs, frees, barriers;
    logic [ced_pkg::DATA_W-1:0] copied, allocated;
    logic [ced_pkg::DATA_W-1:0] wcount, wsum, wmin, wmax, wavg;
    logic [ced_pkg::DATA_W-1:0] errors, timeouts;
  } counters_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [ced_pkg::ACT_W-1:0]  in_action = ced_pkg::ACT_SUBMIT;
  logic [ced_pkg::KIND_W-1:0] in_command_type = '0;
  logic [ced_pkg::DATA_W-1:0] in_amount = '0;
  logic [ced_pkg::IDX_W-1:0]  in_stat_index = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [ced_pkg::DATA_W-1:0] out_read_value;
  logic [ced_pkg::IDX_W-1:0]  out_read_index;

  counters_t   tally;
  read_word_t  pending_reads[$];
  int unsigned fail_count = 0;
  bit          quiet_phase = 1'b0;

  command_event_statistics_core #(
    .COUNTER_BITS(CNT_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_command_type(in_command_type),
    .in_amount(in_amount),
    .in_stat_index(in_stat_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_read_value(out_read_value),
    .out_read_index(out_read_index)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [ced_pkg::DATA_W-1:0] wrap_add(
      input logic [ced_pkg::DATA_W-1:0] a, b);
    return (a + b) & CNT_MASK;
  endfunction

  function automatic void reset_tally();
    tally = '0;
    tally.wmin = CNT_MASK;
  endfunction

  // Applies one event to the shadow counters; returns 1 when it yields a read word.
  function automatic bit step_tally(input stim_t s,
                                    output logic [ced_pkg::DATA_W-1:0] value);
    logic [ced_pkg::DATA_W-1:0] amt;
    amt = s.amount & CNT_MASK;
    value = '0;
    case (s.action)
      ced_pkg::ACT_SUBMIT: begin
        tally.submits = wrap_add(tally.submits, 64'd1);
        case (s.kind)
          ced_pkg::KIND_COPY:    tally.copies = wrap_add(tally.copies, 64'd1);
          ced_pkg::KIND_KERNEL:  tally.kernels = wrap_add(tally.kernels, 64'd1);
          ced_pkg::KIND_ALLOC:   tally.allocs = wrap_add(tally.allocs, 64'd1);
          ced_pkg::KIND_FREE:    tally.frees = wrap_add(tally.frees, 64'd1);
          ced_pkg::KIND_BARRIER: tally.barriers = wrap_add(tally.barriers, 64'd1);
          default: ;
        endcase
      end
      ced_pkg::ACT_COPY:    tally.copied = wrap_add(tally.copied, amt);
      ced_pkg::ACT_ALLOC:   tally.allocated = wrap_add(tally.allocated, amt);
      ced_pkg::ACT_WAIT: begin
        if (amt < tally.wmin) tally.wmin = amt;
        if (amt > tally.wmax) tally.wmax = amt;
        tally.wsum = wrap_add(tally.wsum, amt);
        tally.wcount = wrap_add(tally.wcount, 64'd1);
        // a wrapped sample count gives a zero average rather than a divide by zero
        tally.wavg = (tally.wcount != '0) ? tally.wsum / tally.wcount : '0;
      end
      ced_pkg::ACT_ERROR:   tally.errors = wrap_add(tally.errors, 64'd1);
      ced_pkg::ACT_TIMEOUT: tally.timeouts = wrap_add(tally.timeouts, 64'd1);
      ced_pkg::ACT_READ: begin
        case (s.index)
          ced_pkg::STAT_SUBMIT:    value = tally.submits;
          ced_pkg::STAT_COPY:      value = tally.copies;
          ced_pkg::STAT_KERNEL:    value = tally.kernels;
          ced_pkg::STAT_ALLOC:     value = tally.allocs;
          ced_pkg::STAT_FREE:      value = tally.frees;
          ced_pkg::STAT_BARRIER:   value = tally.barriers;
          ced_pkg::STAT_COPIED:    value = tally.copied;
          ced_pkg::STAT_ALLOCATED: value = tally.allocated;
          ced_pkg::STAT_WCOUNT:    value = tally.wcount;
          ced_pkg::STAT_WAVG:      value = tally.wavg;
          ced_pkg::STAT_WMIN:      value = tally.wmin;
          ced_pkg::STAT_WMAX:      value = tally.wmax;
          ced_pkg::STAT_ERROR:     value = tally.errors;
          ced_pkg::STAT_TIMEOUT:   value = tally.timeouts;
          default:                 value = '0;
        endcase
        return 1'b1;
      end
      default: reset_tally();
    endcase
    return 1'b0;
  endfunction

  // mostly back to back, some short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 80);
  endfunction

  function automatic logic [ced_pkg::DATA_W-1:0] random_amount();
    logic [ced_pkg::DATA_W-1:0] a;
    a = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: a = {32'd0, $urandom_range(0, 4096)};
      1: ;
      2: a = ALL_ONES - {32'd0, $urandom_range(0, 3)};
      3: a = 64'd1 << $urandom_range(0, 63);
      4: a = a >> $urandom_range(0, 63);
      default: a = {32'd0, $urandom_range(0, 1)};
    endcase
    return a;
  endfunction

  function automatic stim_t stim_row(input ced_pkg::action_t a, input ced_pkg::kind_t k,
                                     input logic [ced_pkg::DATA_W-1:0] amt,
                                     input ced_pkg::stat_idx_t idx,
                                     input logic pin,
                                     input logic [ced_pkg::DATA_W-1:0] pin_val);
    stim_t s;
    s.action = a;
    s.kind = k;
    s.amount = amt;
    s.index = idx;
    s.pinned = pin;
    s.pinned_value = pin_val;
    return s;
  endfunction

  function automatic stim_t random_stim();
    stim_t s;
    int unsigned pick;
    pick = $urandom_range(0, 199);
    s.pinned = 1'b0;
    s.pinned_value = '0;
    s.kind = ced_pkg::kind_t'($urandom_range(0, 255));
    s.amount = random_amount();
    s.index = ced_pkg::stat_idx_t'($urandom_range(0, 15));
    if (pick < 70) begin
      s.action = ced_pkg::ACT_READ;
    end else if (pick < 110) begin
      s.action = ced_pkg::ACT_SUBMIT;
      if ($urandom_range(0, 1) != 0) begin
        s.kind = ced_pkg::kind_t'($urandom_range(ced_pkg::KIND_COPY, ced_pkg::KIND_BARRIER));
      end
    end else if (pick < 135) begin
      s.action = ced_pkg::ACT_WAIT;
    end else if (pick < 155) begin
      s.action = ced_pkg::ACT_COPY;
    end else if (pick < 175) begin
      s.action = ced_pkg::ACT_ALLOC;
    end else if (pick < 186) begin
      s.action = ced_pkg::ACT_ERROR;
    end else if (pick < 197) begin
      s.action = ced_pkg::ACT_TIMEOUT;
    end else begin
      s.action = ced_pkg::ACT_CLEAR;
    end
    return s;
  endfunction

  // Holds one event word until taken, then updates the shadow counters.
  task automatic send_stim(input stim_t s);
    int unsigned gap;
    logic [ced_pkg::DATA_W-1:0] value;
    read_word_t word;
    gap = quiet_phase ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= s.action;
    in_command_type <= s.kind;
    in_amount       <= s.amount;
    in_stat_index   <= s.index;
    do @(posedge clk); while (in_stall);
    if (step_tally(s, value)) begin
      word.value = s.pinned ? s.pinned_value : value;
      word.index = s.index;
      pending_reads.push_back(word);
    end
  endtask

  initial begin : out_stall_gen
    int unsigned hold;
    forever begin
      out_stall <= 1'b0;
      hold = $urandom_range(1, 12);
      repeat (hold) @(posedge clk);
      hold = quiet_phase ? 0 : idle_len();
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    read_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected read word: read_value %h read_index %0d",
               out_read_value, out_read_index);
        fail_count++;
      end else begin
        want = pending_reads.pop_front();
        if (out_read_value !== want.value) begin
          $error("read_value: expected %h, got %h", want.value, out_read_value);
          fail_count++;
        end
        if (out_read_index !== want.index) begin
          $error("read_index: expected %0d, got %0d", want.index, out_read_index);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    stim_t rows[$];
    int unsigned n;
    reset_tally();
    // reset values and the spare indexes
    rows.push_back(stim_row(ced_pkg::ACT_READ, '0, '0, ced_pkg::STAT_WMIN, 1'b1, ALL_ONES));
    rows.push_back(stim_row(ced_pkg::ACT_READ, '0, '0, ced_pkg::STAT_SUBMIT, 1'b1, '0));
    rows.push_back(stim_row(ced_pkg::ACT_READ, '0, ALL_ONES, STAT_SPARE_LO, 1'b1, '0));
    rows.push_back(stim_row(ced_pkg::ACT_READ, 8'hFF, '0, STAT_SPARE_HI, 1'b1, '0));
    // every command kind, plus one that only counts toward the total
    rows.push_back(stim_row(ced_pkg::ACT_SUBMIT, ced_pkg::KIND_COPY, '0, '0, 1'b0, '0));
    rows.push_back(stim_row(ced_pkg::ACT_SUBMIT, ced_pkg::KIND_KERNEL, '0, '0, 1'b0, '0));
    rows.push_back(stim_row(ced_pkg::ACT_SUBMIT, ced_pkg::KIND_ALLOC, '0, '0, 1'b0, '0));
    rows.push_back(stim_row(ced_pkg::ACT_SUBMIT, ced_pkg::KIND_FREE, '0, '0, 1'b0, '0));
    rows.push_back(stim_row(ced_pkg::ACT_SUBMIT, ced_pkg::KIND_BARRIER, '0, '0, 1'b0, '0));
    rows.push_back(stim_row(ced_pkg::ACT_SUBMIT, 8'hFF, ALL_ONES, STAT_SPARE_HI, 1'b0, '0));
    // copied bytes wrap back to zero
    rows.push_back(stim_row(ced_pkg::ACT_COPY, '0, ALL_ONES, '0, 1'b0, '0));
    rows.push_back(stim_row(ced_pkg::ACT_COPY, '0, 64'd1, '0, 1'b0, '0));
    rows.push_back(stim_row(ced_pkg::ACT_READ, '0, '0, ced_pkg::STAT_COPIED, 1'b1, '0));
    rows.push_back(stim_row(ced_pkg::ACT_ALLOC, '0, 64'h8000_0000_0000_0000, '0, 1'b0, '0));
    // wait extremes
    rows.push_back(stim_row(ced_pkg::ACT_WAIT, '0, '0, '0, 1'b0, '0));
    rows.push_back(stim_row(ced_pkg::ACT_WAIT, '0, ALL_ONES, '0, 1'b0, '0));
    rows.push_back(stim_row(ced_pkg::ACT_READ, '0, '0, ced_pkg::STAT_WMIN, 1'b1, '0));
    rows.push_back(stim_row(ced_pkg::ACT_READ, '0, '0, ced_pkg::STAT_WMAX, 1'b1, ALL_ONES));
    rows.push_back(stim_row(ced_pkg::ACT_READ, '0, '0, ced_pkg::STAT_WAVG, 1'b0, '0));
    rows.push_back(stim_row(ced_pkg::ACT_ERROR, '0, '0, '0, 1'b0, '0));
    rows.push_back(stim_row(ced_pkg::ACT_TIMEOUT, '0, '0, '0, 1'b0, '0));
    rows.push_back(stim_row(ced_pkg::ACT_READ, '0, '0, ced_pkg::STAT_SUBMIT, 1'b0, '0));
    // clear brings the minimum back to all ones
    rows.push_back(stim_row(ced_pkg::ACT_CLEAR, '0, '0, '0, 1'b0, '0));
    rows.push_back(stim_row(ced_pkg::ACT_READ, '0, '0, ced_pkg::STAT_WMIN, 1'b1, ALL_ONES));
    rows.push_back(stim_row(ced_pkg::ACT_READ, '0, '0, ced_pkg::STAT_ERROR, 1'b1, '0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_stim(rows[i]);
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // every fourth stretch runs with no gaps and no stalls
      quiet_phase = ((n / 150) % 4) == 3;
      send_stim(random_stim());
    end
    quiet_phase = 1'b0;
    in_valid <= 1'b0;

    while (pending_reads.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ced_pkg.sv
rtl/ced_div.sv
rtl/command_event_statistics_core.sv
verif/tb_command_event_statistics_core.sv
